// ===== rtl/upc_pkg.sv =====
// ----------------------------------------------------------------------------
// upc_pkg
// shared types, constants and character-class functions for the percent codec
// ----------------------------------------------------------------------------
package upc_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_MODE         = 2'd0;
  localparam logic [1:0] REG_FORBID_SLASH = 2'd1;
  localparam logic [1:0] REG_ALLOWED_SET  = 2'd2;

  // allowed reserved sets in encode mode
  localparam logic [1:0] SET_NONE       = 2'd0;
  localparam logic [1:0] SET_SUB_COLON  = 2'd1;
  localparam logic [1:0] SET_SUB_PCHAR  = 2'd2;

  // escape phases of the decoder
  localparam logic [1:0] PHASE_IDLE = 2'd0;
  localparam logic [1:0] PHASE_HIGH = 2'd1;
  localparam logic [1:0] PHASE_LOW  = 2'd2;

  // characters
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SLASH   = 8'h2F;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // beat index inside an escape expansion
  localparam logic [1:0] BEAT_PERCENT = 2'd0;
  localparam logic [1:0] BEAT_HIGH    = 2'd1;
  localparam logic [1:0] BEAT_LOW     = 2'd2;

  typedef enum logic [1:0] {
    OP_SINGLE  = 2'd0,  // one data beat
    OP_ESCAPE  = 2'd1,  // three beats: '%', high digit, low digit
    OP_ERR_END = 2'd2   // bare end marker with error
  } upc_op_t;

  typedef struct packed {
    upc_op_t    op;
    logic [7:0] data;
    logic       last;
  } upc_entry_t;

  typedef struct packed {
    logic mode;
    logic forbid_slash;
    logic [1:0] allowed_set;
  } upc_cfg_t;

  // {valid, value} of a hex digit, either case
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] t;
    logic       ok;
    t  = 8'h00;
    ok = 1'b0;
    if (c >= 8'h30 && c <= 8'h39) begin
      t  = c - 8'h30;
      ok = 1'b1;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      t  = c - 8'h37;
      ok = 1'b1;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      t  = c - 8'h57;
      ok = 1'b1;
    end
    return {ok, t[3:0]};
  endfunction

  // upper-case hex digit of a nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) begin
      r = 8'h30 + {4'h0, n};
    end else begin
      r = 8'h37 + {4'h0, n};
    end
    return r;
  endfunction

  function automatic logic is_sub_delim(input logic [7:0] c);
    return c == 8'h21 || c == 8'h24 || c == 8'h26 || c == 8'h27 || c == 8'h28 ||
           c == 8'h29 || c == 8'h2A || c == 8'h2B || c == 8'h2C || c == 8'h3B ||
           c == 8'h3D;
  endfunction

  // byte goes out unchanged in encode mode
  function automatic logic passes(input logic [7:0] c, input logic [1:0] set);
    logic unres;
    logic res;
    unres = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
            (c >= 8'h61 && c <= 8'h7A) || c == 8'h2D || c == 8'h2E ||
            c == 8'h5F || c == 8'h7E;
    res = 1'b0;
    if (set == SET_SUB_COLON || set == SET_SUB_PCHAR) begin
      res = is_sub_delim(c) || c == 8'h3A;
      if (set == SET_SUB_PCHAR && (c == 8'h40 || c == CH_SLASH)) begin
        res = 1'b1;
      end
    end
    return unres || res;
  endfunction

endpackage

// ===== rtl/upc_front.sv =====
// ----------------------------------------------------------------------------
// upc_front
// accepts input bytes, tracks escape state and issues one command per result
// ----------------------------------------------------------------------------
module upc_front (
  input  logic              clk,
  input  logic              rst,
  input  upc_pkg::upc_cfg_t cfg,
  input  logic              accept,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  output logic              push,
  output upc_pkg::upc_entry_t entry
);
  import upc_pkg::*;

  logic [1:0] escape_phase, escape_phase_next;
  logic [3:0] high_nibble, high_nibble_next;
  logic       discarding, discarding_next;

  logic [1:0] phase;
  logic [4:0] hv;
  logic [7:0] decoded;
  logic       err;
  logic       emit;

  assign phase   = (escape_phase == PHASE_IDLE || escape_phase == PHASE_HIGH ||
                    escape_phase == PHASE_LOW) ? escape_phase : PHASE_IDLE;
  assign hv      = hex_value(in_byte);
  assign decoded = {high_nibble, hv[3:0]};

  always_comb begin
    escape_phase_next = escape_phase;
    high_nibble_next  = high_nibble;
    discarding_next   = discarding;
    err               = 1'b0;
    emit              = 1'b0;
    entry.op          = OP_SINGLE;
    entry.data        = in_byte;
    entry.last        = in_last;

    if (cfg.mode) begin
      emit     = 1'b1;
      entry.op = passes(in_byte, cfg.allowed_set) ? OP_SINGLE : OP_ESCAPE;
    end else begin
      if (!discarding) begin
        case (phase)
          PHASE_HIGH: begin
            if (!hv[4]) begin
              err = 1'b1;
            end else begin
              high_nibble_next  = hv[3:0];
              escape_phase_next = PHASE_LOW;
              err               = in_last;
            end
          end
          PHASE_LOW: begin
            escape_phase_next = PHASE_IDLE;
            if (!hv[4] || decoded == 8'h00 || (cfg.forbid_slash && decoded == CH_SLASH)) begin
              err = 1'b1;
            end else begin
              emit       = 1'b1;
              entry.data = decoded;
            end
          end
          default: begin
            if (in_byte == CH_PERCENT) begin
              escape_phase_next = PHASE_HIGH;
              err               = in_last;
            end else begin
              emit = 1'b1;
            end
          end
        endcase
        if (err) begin
          discarding_next   = 1'b1;
          escape_phase_next = PHASE_IDLE;
          high_nibble_next  = 4'h0;
        end
      end
      // error end marker replaces anything else on the last byte
      if (discarding_next && in_last) begin
        emit       = 1'b1;
        entry.op   = OP_ERR_END;
        entry.data = 8'h00;
      end
    end

    if (in_last) begin
      escape_phase_next = PHASE_IDLE;
      high_nibble_next  = 4'h0;
      discarding_next   = 1'b0;
    end
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_phase <= PHASE_IDLE;
      high_nibble  <= 4'h0;
      discarding   <= 1'b0;
    end else if (accept) begin
      escape_phase <= escape_phase_next;
      high_nibble  <= high_nibble_next;
      discarding   <= discarding_next;
    end
  end

endmodule

// ===== rtl/upc_queue.sv =====
// ----------------------------------------------------------------------------
// upc_queue
// short command queue decoupling the front from the back
// ----------------------------------------------------------------------------
module upc_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  upc_pkg::upc_entry_t push_entry,
  input  logic                pop,
  output upc_pkg::upc_entry_t head,
  output logic                empty,
  output logic                full
);
  import upc_pkg::*;

  upc_entry_t        slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign empty = (count == QCNT_W'(0));
  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/upc_back.sv =====
// ----------------------------------------------------------------------------
// upc_back
// expands queued commands into output beats and holds the output register
// ----------------------------------------------------------------------------
module upc_back (
  input  logic                clk,
  input  logic                rst,
  input  upc_pkg::upc_entry_t head,
  input  logic                empty,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                has_byte,
  output logic                out_last,
  output logic                error
);
  import upc_pkg::*;

  logic [1:0] beat_idx, beat_idx_next;
  logic       load;
  logic       final_beat;
  logic [7:0] beat_byte;
  logic       beat_has;
  logic       beat_last;
  logic       beat_err;

  assign load       = (!out_valid || out_ready) && !empty;
  assign final_beat = (head.op != OP_ESCAPE) || (beat_idx == BEAT_LOW);
  assign pop        = load && final_beat;

  always_comb begin
    beat_byte     = head.data;
    beat_has      = 1'b1;
    beat_last     = head.last;
    beat_err      = 1'b0;
    beat_idx_next = final_beat ? BEAT_PERCENT : beat_idx + 1'b1;
    case (head.op)
      OP_ESCAPE: begin
        case (beat_idx)
          BEAT_HIGH: begin
            beat_byte = hex_digit(head.data[7:4]);
            beat_last = 1'b0;
          end
          BEAT_LOW: begin
            beat_byte = hex_digit(head.data[3:0]);
          end
          default: begin
            beat_byte = CH_PERCENT;
            beat_last = 1'b0;
          end
        endcase
      end
      OP_ERR_END: begin
        beat_byte = 8'h00;
        beat_has  = 1'b0;
        beat_last = 1'b1;
        beat_err  = 1'b1;
      end
      default: begin
        beat_byte = head.data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      beat_idx  <= BEAT_PERCENT;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        beat_idx  <= beat_idx_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= beat_byte;
      has_byte <= beat_has;
      out_last <= beat_last;
      error    <= beat_err;
    end
  end

endmodule

// ===== rtl/uri_percent_codec_unit.sv =====
// ----------------------------------------------------------------------------
// uri_percent_codec_unit
// streaming percent codec: decodes %XX escapes or encodes bytes into them
// ----------------------------------------------------------------------------
//
//   channel   handshake             payload
//   -------   -------------------   -------------------------------------
//   input     in_valid / in_ready   in_byte, in_last
//   output    out_valid / out_ready out_byte, has_byte, out_last, error
//   config    cfg_we                cfg_index, cfg_data
//
// - one input byte per cycle while the queue has room; a result is written
//   into the command queue, then loaded into the output register
// - an escaped byte in encode mode takes three output beats, so the back end
//   keeps its command at the queue head until the last beat is loaded
// - in_ready falls only when the four-entry command queue is full
// - synchronous active-high reset clears cfg, out_valid, escape and queue
// - out_ready low stalls the back end only; the front keeps taking bytes
//   until the queue fills
//
module uri_percent_codec_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       out_last,
  output logic       error,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [1:0] cfg_data
);
  import upc_pkg::*;

  upc_cfg_t   cfg;
  upc_entry_t push_entry;
  upc_entry_t head;
  logic       push;
  logic       pop;
  logic       q_empty;
  logic       q_full;
  logic       in_beat;

  // configuration registers; the user must write them only while the block is idle (not enforced)
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:         cfg.mode         <= cfg_data[0];
        REG_FORBID_SLASH: cfg.forbid_slash <= cfg_data[0];
        REG_ALLOWED_SET:  cfg.allowed_set  <= cfg_data;
        default: begin
          // unmapped index, write dropped
        end
      endcase
    end
  end

  // front takes a beat whenever the queue has room
  assign in_ready = !q_full;
  assign in_beat  = in_valid && in_ready;

  // classify the byte, keep escape state, issue at most one command
  upc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .accept  (in_beat),
    .in_byte (in_byte),
    .in_last (in_last),
    .push    (push),
    .entry   (push_entry)
  );

  // command queue between the two halves
  upc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  // expand commands into output beats
  upc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .has_byte  (has_byte),
    .out_last  (out_last),
    .error     (error)
  );

`ifndef SYNTHESIS
  // queue never written while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && q_full))
    else $error("command queue overflow");

  // queue never read while empty
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && q_empty))
    else $error("command queue underflow");

  // an error beat is a bare end marker
  a_err_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> !has_byte && out_last && out_byte == 8'h00)
    else $error("error beat is not a bare end marker");

  // a byte-less beat always closes the string
  a_bare_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_byte |-> out_last && error)
    else $error("bare beat without end and error");
`endif

endmodule
